// ===== hw/rtl/s2c_pkg.sv =====
// shared types, constants and helpers for the spherical to cartesian converter
// no dependencies; compile first

package s2c_pkg;

    localparam int RA_W   = 20;
    localparam int RHO_W  = 17;
    localparam int POS_W  = 18;

    typedef logic signed [RA_W-1:0]  t_angle;
    typedef logic        [RHO_W-1:0] t_radius;
    typedef logic signed [POS_W-1:0] t_pos;

    localparam int OUT_MAX = 131071;
    localparam int OUT_MIN = -131072;

    // arctangent table, atan(2^-i) at 32 fraction bits
    localparam int ATAN_ENTRIES = 24;
    localparam logic [31:0] ATAN_Q32 [ATAN_ENTRIES] = '{
        32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
        32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
        32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
        32'd1048576,    32'd524288,     32'd262144,     32'd131072,
        32'd65536,      32'd32768,      32'd16384,      32'd8192,
        32'd4096,       32'd2048,       32'd1024,       32'd512
    };

    // cordic gain for unlimited stages, 32 fraction bits
    localparam logic signed [32:0] K_Q32       = 33'sd2608131496;
    localparam logic signed [39:0] PI_Q32      = 40'sd13493037705;
    localparam logic signed [39:0] HALF_PI_Q32 = 40'sd6746518852;
    localparam logic signed [39:0] TWO_PI_Q32  = 40'sd26986075409;

    // round a 32 fraction bit constant to frac fraction bits, ties up
    function automatic logic signed [39:0] round_q32(input logic signed [39:0] c,
                                                     input int frac);
        logic signed [39:0] half;
        half = 40'sd1 <<< (31 - frac);
        return (c + half) >>> (32 - frac);
    endfunction

endpackage

// ===== hw/rtl/s2c_if.sv =====
// request and result channel interfaces of the spherical to cartesian converter
// depends on s2c_pkg

interface s2c_in_if;
    import s2c_pkg::*;

    logic    valid;
    logic    ready;
    t_angle  right_ascension;
    t_angle  declination;
    t_radius radius;

    modport source (output valid, right_ascension, declination, radius, input ready);
    modport sink   (input valid, right_ascension, declination, radius, output ready);
endinterface

interface s2c_out_if;
    import s2c_pkg::*;

    logic valid;
    logic ready;
    t_pos pos_x;
    t_pos pos_y;
    t_pos pos_z;

    modport source (output valid, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== hw/rtl/s2c_cell.sv =====
// one cordic rotation cell: a shift-add micro-rotation with its own registers
// depends on s2c_pkg

module s2c_cell #(
    parameter int STAGE     = 0,
    parameter int FRAC_BITS = 16,
    parameter int W_XY      = 20,
    parameter int W_ANG     = 21,
    parameter int SIDE_W    = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [W_XY-1:0]  i_x,
    input  logic signed [W_XY-1:0]  i_y,
    input  logic signed [W_ANG-1:0] i_z,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic signed [W_XY-1:0]  o_x,
    output logic signed [W_XY-1:0]  o_y,
    output logic signed [W_ANG-1:0] o_z,
    output logic [SIDE_W-1:0]       o_side
);
    import s2c_pkg::*;

    logic signed [W_XY-1:0]  n_x;
    logic signed [W_XY-1:0]  n_y;
    logic signed [W_ANG-1:0] n_z;

    logic                    r_valid;
    logic signed [W_XY-1:0]  r_x;
    logic signed [W_XY-1:0]  r_y;
    logic signed [W_ANG-1:0] r_z;
    logic [SIDE_W-1:0]       r_side;

    generate
        if (STAGE < ATAN_ENTRIES) begin : g_rot
            localparam logic signed [39:0] T_WIDE =
                round_q32($signed({8'd0, ATAN_Q32[STAGE]}), FRAC_BITS);
            localparam logic signed [W_ANG-1:0] T_F = T_WIDE[W_ANG-1:0];

            logic signed [W_XY-1:0] w_xs;
            logic signed [W_XY-1:0] w_ys;

            always_comb begin
                w_xs = i_x >>> STAGE;
                w_ys = i_y >>> STAGE;
                if (!i_z[W_ANG-1]) begin
                    n_x = i_x - w_ys;
                    n_y = i_y + w_xs;
                    n_z = i_z - T_F;
                end else begin
                    n_x = i_x + w_ys;
                    n_y = i_y - w_xs;
                    n_z = i_z + T_F;
                end
            end
        end else begin : g_pass
            // past the end of the angle table a stage changes nothing
            assign n_x = i_x;
            assign n_y = i_y;
            assign n_z = i_z;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_side  = r_side;

endmodule

// ===== hw/rtl/s2c_chain.sv =====
// one cordic rotation: gain pre-scale (multiply, then round) and a row of cells
// depends on s2c_pkg and s2c_cell

module s2c_chain #(
    parameter int STAGES    = 16,
    parameter int FRAC_BITS = 16,
    parameter int W_XY      = 20,
    parameter int W_ANG     = 21,
    parameter int SIDE_W    = 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [W_XY-1:0]  i_x0,
    input  logic signed [W_ANG-1:0] i_ang,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic signed [W_XY-1:0]  o_x,
    output logic signed [W_XY-1:0]  o_y,
    output logic [SIDE_W-1:0]       o_side
);
    import s2c_pkg::*;

    localparam int W_P = W_XY + 33;
    localparam logic signed [W_P-1:0] HALF_Q32 = W_P'(1) <<< 31;

    // gain multiply stage
    logic                    r_m_valid;
    logic signed [W_P-1:0]   r_m_prod;
    logic signed [W_ANG-1:0] r_m_ang;
    logic [SIDE_W-1:0]       r_m_side;
    logic signed [W_P-1:0]   n_m_prod;

    // rounding stage
    logic                    r_s_valid;
    logic signed [W_XY-1:0]  r_s_x;
    logic signed [W_ANG-1:0] r_s_ang;
    logic [SIDE_W-1:0]       r_s_side;
    logic signed [W_P-1:0]   w_round;
    logic signed [W_P-1:0]   w_shift;
    logic signed [W_XY-1:0]  n_s_x;

    assign n_m_prod = i_x0 * K_Q32;
    assign w_round  = r_m_prod + HALF_Q32;
    assign w_shift  = w_round >>> 32;
    assign n_s_x    = w_shift[W_XY-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else if (i_en) begin
            r_m_valid <= i_valid;
            r_s_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_prod <= n_m_prod;
            r_m_ang  <= i_ang;
            r_m_side <= i_side;
            r_s_x    <= n_s_x;
            r_s_ang  <= r_m_ang;
            r_s_side <= r_m_side;
        end
    end

    logic                    c_valid [STAGES+1];
    logic signed [W_XY-1:0]  c_x     [STAGES+1];
    logic signed [W_XY-1:0]  c_y     [STAGES+1];
    logic signed [W_ANG-1:0] c_z     [STAGES+1];
    logic [SIDE_W-1:0]       c_side  [STAGES+1];

    assign c_valid[0] = r_s_valid;
    assign c_x[0]     = r_s_x;
    assign c_y[0]     = '0;
    assign c_z[0]     = r_s_ang;
    assign c_side[0]  = r_s_side;

    generate
        for (genvar g = 0; g < STAGES; g++) begin : g_cell
            s2c_cell #(
                .STAGE     (g),
                .FRAC_BITS (FRAC_BITS),
                .W_XY      (W_XY),
                .W_ANG     (W_ANG),
                .SIDE_W    (SIDE_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (i_en),
                .i_valid (c_valid[g]),
                .i_x     (c_x[g]),
                .i_y     (c_y[g]),
                .i_z     (c_z[g]),
                .i_side  (c_side[g]),
                .o_valid (c_valid[g+1]),
                .o_x     (c_x[g+1]),
                .o_y     (c_y[g+1]),
                .o_z     (c_z[g+1]),
                .o_side  (c_side[g+1])
            );
        end
    endgenerate

    // residual angle of the last cell is not needed
    assign o_valid = c_valid[STAGES];
    assign o_x     = c_x[STAGES];
    assign o_y     = c_y[STAGES];
    assign o_side  = c_side[STAGES];

endmodule

// ===== hw/rtl/spherical_to_cartesian.sv =====
// Spherical to cartesian converter. Each request carries a right ascension and a
// declination (signed Q4.16 radians) and a radius (unsigned Q1.16); the result is
// x = r*cos(de)*cos(ra), y = r*cos(de)*sin(ra), z = r*sin(de), signed Q1.16 and
// saturated. The datapath is fully pipelined: one request is taken every clock
// unless the pipe stalls. Each request passes the format and fold registers, two
// rows of CORDIC cells, one cell per stage, each row behind its gain multiply and
// rounding registers, half turn registers and the output register. A single enable
// moves the whole pipe; it drops only while the output register holds a result
// that is not taken, so the request side sees ready low exactly then. There is no
// state between requests. Internal arithmetic runs at FRAC_BITS fraction bits.
// depends on s2c_pkg, s2c_if, s2c_chain and s2c_cell

module spherical_to_cartesian #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    s2c_in_if.sink    i_in,
    s2c_out_if.source o_out
);
    import s2c_pkg::*;

    // widths: vectors up to about +-8, angles up to about +-16 before reduction
    localparam int W_XY  = FRAC_BITS + 4;
    localparam int W_ANG = FRAC_BITS + 5;
    localparam int W_PRE = FRAC_BITS + 11;

    // format change between Q16 ports and the internal fraction width
    localparam int SH_DN = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam logic signed [W_PRE-1:0] HALF_UP = (W_PRE'(1) <<< SH_UP) >> 1;
    localparam logic signed [W_PRE-1:0] HALF_DN = (W_PRE'(1) <<< SH_DN) >> 1;

    localparam logic signed [W_PRE-1:0] SAT_HI = W_PRE'(OUT_MAX);
    localparam logic signed [W_PRE-1:0] SAT_LO = W_PRE'(OUT_MIN);
    localparam t_pos POS_MAX = t_pos'(OUT_MAX);
    localparam t_pos POS_MIN = t_pos'(OUT_MIN);

    // angle constants at the internal fraction width
    localparam logic signed [39:0] PI_WIDE  = round_q32(PI_Q32, FRAC_BITS);
    localparam logic signed [39:0] HPI_WIDE = round_q32(HALF_PI_Q32, FRAC_BITS);
    localparam logic signed [39:0] TPI_WIDE = round_q32(TWO_PI_Q32, FRAC_BITS);
    localparam logic signed [W_ANG-1:0] PI_F  = PI_WIDE[W_ANG-1:0];
    localparam logic signed [W_ANG-1:0] HPI_F = HPI_WIDE[W_ANG-1:0];
    localparam logic signed [W_ANG-1:0] TPI_F = TPI_WIDE[W_ANG-1:0];

    localparam int SIDE1_W = W_ANG + 2;
    localparam int SIDE2_W = W_XY + 1;

    // Q4.16 angle to internal format, ties rounded up
    function automatic logic signed [W_ANG-1:0] f_ang_in(input t_angle a);
        logic signed [W_PRE-1:0] e;
        e = W_PRE'(a);
        e = ((e <<< SH_DN) + HALF_UP) >>> SH_UP;
        return e[W_ANG-1:0];
    endfunction

    // one turn brings any input angle into [-pi, pi]
    function automatic logic signed [W_ANG-1:0] f_wrap(input logic signed [W_ANG-1:0] a);
        if (a > PI_F) begin
            return a - TPI_F;
        end else if (a < -PI_F) begin
            return a + TPI_F;
        end else begin
            return a;
        end
    endfunction

    // internal vector component back to Q1.16 with saturation
    function automatic t_pos f_emit(input logic signed [W_XY-1:0] v);
        logic signed [W_PRE-1:0] e;
        e = W_PRE'(v);
        e = ((e <<< SH_UP) + HALF_DN) >>> SH_DN;
        if (e > SAT_HI) begin
            return POS_MAX;
        end else if (e < SAT_LO) begin
            return POS_MIN;
        end else begin
            return e[POS_W-1:0];
        end
    endfunction

    // pipeline enable: everything moves unless the output holds a result that is not taken
    logic w_en;
    logic r_o_valid;

    assign w_en       = !r_o_valid || o_out.ready;
    assign i_in.ready = w_en;

    // stage a: format change and turn wrap
    logic                    r_a_valid;
    logic signed [W_ANG-1:0] r_a_ra;
    logic signed [W_ANG-1:0] r_a_de;
    logic signed [W_XY-1:0]  r_a_rho;
    logic signed [W_PRE-1:0] w_rho_ext;
    logic signed [W_PRE-1:0] w_rho_f;

    assign w_rho_ext = W_PRE'(i_in.radius);
    assign w_rho_f   = ((w_rho_ext <<< SH_DN) + HALF_UP) >>> SH_UP;

    // stage b: fold into [-pi/2, pi/2], remembering a half turn
    logic                    r_b_valid;
    logic signed [W_ANG-1:0] r_b_ra;
    logic signed [W_ANG-1:0] r_b_de;
    logic                    r_b_neg_ra;
    logic                    r_b_neg_de;
    logic signed [W_XY-1:0]  r_b_rho;
    logic signed [W_ANG-1:0] n_b_ra;
    logic signed [W_ANG-1:0] n_b_de;
    logic                    n_b_neg_ra;
    logic                    n_b_neg_de;

    always_comb begin
        n_b_ra     = r_a_ra;
        n_b_neg_ra = 1'b0;
        if (r_a_ra > HPI_F) begin
            n_b_ra     = r_a_ra - PI_F;
            n_b_neg_ra = 1'b1;
        end else if (r_a_ra < -HPI_F) begin
            n_b_ra     = r_a_ra + PI_F;
            n_b_neg_ra = 1'b1;
        end
        n_b_de     = r_a_de;
        n_b_neg_de = 1'b0;
        if (r_a_de > HPI_F) begin
            n_b_de     = r_a_de - PI_F;
            n_b_neg_de = 1'b1;
        end else if (r_a_de < -HPI_F) begin
            n_b_de     = r_a_de + PI_F;
            n_b_neg_de = 1'b1;
        end
    end

    // first rotation by declination: x gives r*cos(de), y gives z
    logic                    w_c1_valid;
    logic signed [W_XY-1:0]  w_c1_x;
    logic signed [W_XY-1:0]  w_c1_y;
    logic [SIDE1_W-1:0]      w_c1_side;
    logic signed [W_ANG-1:0] w_c1_ra;
    logic                    w_c1_neg_ra;
    logic                    w_c1_neg_de;

    s2c_chain #(
        .STAGES    (CORDIC_STAGES),
        .FRAC_BITS (FRAC_BITS),
        .W_XY      (W_XY),
        .W_ANG     (W_ANG),
        .SIDE_W    (SIDE1_W)
    ) u_chain_de (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_b_valid),
        .i_x0    (r_b_rho),
        .i_ang   (r_b_de),
        .i_side  ({r_b_ra, r_b_neg_ra, r_b_neg_de}),
        .o_valid (w_c1_valid),
        .o_x     (w_c1_x),
        .o_y     (w_c1_y),
        .o_side  (w_c1_side)
    );

    assign {w_c1_ra, w_c1_neg_ra, w_c1_neg_de} = w_c1_side;

    // mid stage: undo the declination half turn
    logic                    r_m_valid;
    logic signed [W_XY-1:0]  r_m_p;
    logic signed [W_XY-1:0]  r_m_z;
    logic signed [W_ANG-1:0] r_m_ra;
    logic                    r_m_neg_ra;

    // second rotation by right ascension: x and y
    logic                    w_c2_valid;
    logic signed [W_XY-1:0]  w_c2_x;
    logic signed [W_XY-1:0]  w_c2_y;
    logic [SIDE2_W-1:0]      w_c2_side;
    logic signed [W_XY-1:0]  w_c2_z;
    logic                    w_c2_neg_ra;

    s2c_chain #(
        .STAGES    (CORDIC_STAGES),
        .FRAC_BITS (FRAC_BITS),
        .W_XY      (W_XY),
        .W_ANG     (W_ANG),
        .SIDE_W    (SIDE2_W)
    ) u_chain_ra (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m_valid),
        .i_x0    (r_m_p),
        .i_ang   (r_m_ra),
        .i_side  ({r_m_z, r_m_neg_ra}),
        .o_valid (w_c2_valid),
        .o_x     (w_c2_x),
        .o_y     (w_c2_y),
        .o_side  (w_c2_side)
    );

    assign {w_c2_z, w_c2_neg_ra} = w_c2_side;

    // stage n: undo the right ascension half turn
    logic                   r_n_valid;
    logic signed [W_XY-1:0] r_n_x;
    logic signed [W_XY-1:0] r_n_y;
    logic signed [W_XY-1:0] r_n_z;

    // output register: back to Q1.16 and saturate
    t_pos r_o_x;
    t_pos r_o_y;
    t_pos r_o_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_n_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_in.valid;
            r_b_valid <= r_a_valid;
            r_m_valid <= w_c1_valid;
            r_n_valid <= w_c2_valid;
            r_o_valid <= r_n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_ra     <= f_wrap(f_ang_in(i_in.right_ascension));
            r_a_de     <= f_wrap(f_ang_in(i_in.declination));
            r_a_rho    <= w_rho_f[W_XY-1:0];

            r_b_ra     <= n_b_ra;
            r_b_de     <= n_b_de;
            r_b_neg_ra <= n_b_neg_ra;
            r_b_neg_de <= n_b_neg_de;
            r_b_rho    <= r_a_rho;

            r_m_p      <= w_c1_neg_de ? -w_c1_x : w_c1_x;
            r_m_z      <= w_c1_neg_de ? -w_c1_y : w_c1_y;
            r_m_ra     <= w_c1_ra;
            r_m_neg_ra <= w_c1_neg_ra;

            r_n_x      <= w_c2_neg_ra ? -w_c2_x : w_c2_x;
            r_n_y      <= w_c2_neg_ra ? -w_c2_y : w_c2_y;
            r_n_z      <= w_c2_z;

            r_o_x      <= f_emit(r_n_x);
            r_o_y      <= f_emit(r_n_y);
            r_o_z      <= f_emit(r_n_z);
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.pos_x = r_o_x;
    assign o_out.pos_y = r_o_y;
    assign o_out.pos_z = r_o_z;

    // reset empties the pipe
    a_reset_empties: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid right after reset");

    // a held result freezes every stage
    a_stall_freezes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_a_valid) && $stable(r_b_valid) && $stable(r_m_valid)
                  && $stable(r_n_valid))
        else $error("pipeline moved while output stalled");

    // a new result only comes from a valid last stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_n_valid))
        else $error("result appeared without a request behind it");

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for spherical_to_cartesian: directed and random requests
// against a bit-exact cordic predictor. depends on s2c_pkg, s2c_if and the rtl top

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import s2c_pkg::*;

    // block configuration, kept equal to the instance below
    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 16;

    // request to result latency of the pipe
    localparam int PIPE_LATENCY  = 2 * CORDIC_STAGES + 9;
    // cycles without any transfer before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // length of the long receiver hold-off
    localparam int HOLD_OFF_LEN  = 400;

    // fixed point constants at 32 fraction bits, own copies
    localparam longint GAIN_Q32     = 64'd2608131496;
    localparam longint PI_C_Q32     = 64'd13493037705;
    localparam longint HPI_C_Q32    = 64'd6746518852;
    localparam longint TWO_PI_C_Q32 = 64'd26986075409;
    localparam longint POS_HI       = 64'sd131071;
    localparam longint POS_LO       = -64'sd131072;
    localparam int     ARCTAN_LEN   = 24;
    localparam longint ARCTAN_Q32 [ARCTAN_LEN] = '{
        64'd3373259426, 64'd1991351318, 64'd1052175346, 64'd534100635,
        64'd268086748,  64'd134174063,  64'd67103403,   64'd33553749,
        64'd16777131,   64'd8388597,    64'd4194303,    64'd2097152,
        64'd1048576,    64'd524288,     64'd262144,     64'd131072,
        64'd65536,      64'd32768,      64'd16384,      64'd8192,
        64'd4096,       64'd2048,       64'd1024,       64'd512
    };

    // angle landmarks in Q4.16: pi, pi/2 and 2*pi after rounding
    localparam int PI_Q16     = 205887;
    localparam int HPI_Q16    = 102944;
    localparam int TWO_PI_Q16 = 411775;
    localparam int ANGLE_MAX  = 524287;
    localparam int ANGLE_MIN  = -524288;
    localparam int RADIUS_MAX = 131071;
    localparam int RADIUS_ONE = 65536;

    typedef struct packed {
        t_pos x;
        t_pos y;
        t_pos z;
    } t_position;

    logic i_clk;
    logic i_rst_n;

    s2c_in_if  request_ch ();
    s2c_out_if result_ch ();

    spherical_to_cartesian #(
        .CORDIC_STAGES(CORDIC_STAGES),
        .FRAC_BITS    (FRAC_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (request_ch),
        .o_out  (result_ch)
    );

    // positions predicted for requests taken but not yet answered, oldest first
    t_position pending_positions[$];

    int          error_count;
    int          src_idle_pct;
    int          sink_idle_pct;
    bit          hold_off_pending;
    int unsigned idle_cycles;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // add half an lsb then floor, ties go toward plus infinity
    function automatic longint round_down_shift(input longint v, input int s);
        if (s == 0) begin
            return v;
        end
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Q16 input to internal fraction width
    function automatic longint widen_q16(input longint v);
        if (FRAC_BITS >= 16) begin
            return v <<< (FRAC_BITS - 16);
        end
        return round_down_shift(v, 16 - FRAC_BITS);
    endfunction

    // internal fraction width back to Q16
    function automatic longint narrow_q16(input longint v);
        if (FRAC_BITS <= 16) begin
            return v <<< (16 - FRAC_BITS);
        end
        return round_down_shift(v, FRAC_BITS - 16);
    endfunction

    function automatic longint const_at_frac(input longint c);
        return round_down_shift(c, 32 - FRAC_BITS);
    endfunction

    // bring an angle into [-pi/2, pi/2]; flip tells that the rotation outputs
    // must be negated afterwards
    function automatic longint fold_angle(input longint a, output bit flip);
        longint pi_f;
        longint hpi_f;
        longint tpi_f;
        int     g;
        pi_f  = const_at_frac(PI_C_Q32);
        hpi_f = const_at_frac(HPI_C_Q32);
        tpi_f = const_at_frac(TWO_PI_C_Q32);
        for (g = 0; g < 4 && a > pi_f; g++) begin
            a -= tpi_f;
        end
        for (g = 0; g < 4 && a < -pi_f; g++) begin
            a += tpi_f;
        end
        flip = 1'b0;
        if (a > hpi_f) begin
            a -= pi_f;
            flip = 1'b1;
        end else if (a < -hpi_f) begin
            a += pi_f;
            flip = 1'b1;
        end
        return a;
    endfunction

    // rotate (x0, 0) by ang in cordic stages; stages past the table do nothing
    function automatic void cordic_rotate(input longint x0, input longint ang,
                                          output longint xo, output longint yo);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        int     i;
        x = x0;
        y = 0;
        z = ang;
        for (i = 0; i < CORDIC_STAGES && i < ARCTAN_LEN; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            t  = const_at_frac(ARCTAN_Q32[i]);
            if (z >= 0) begin
                x -= ys;
                y += xs;
                z -= t;
            end else begin
                x += ys;
                y -= xs;
                z += t;
            end
        end
        xo = x;
        yo = y;
    endfunction

    function automatic t_pos clamp_position(input longint v);
        longint q;
        q = narrow_q16(v);
        if (q > POS_HI) begin
            q = POS_HI;
        end
        if (q < POS_LO) begin
            q = POS_LO;
        end
        return t_pos'(q);
    endfunction

    // first rotation by declination gives (rho*cos(de), z), the second one
    // rotates rho*cos(de) by right ascension and gives (x, y)
    function automatic t_position predict_position(input t_angle ra, input t_angle de,
                                                   input t_radius rho);
        longint    a_ra;
        longint    a_de;
        longint    r;
        longint    p;
        longint    zc;
        longint    xc;
        longint    yc;
        bit        flip_ra;
        bit        flip_de;
        t_position pos;
        a_de = fold_angle(widen_q16(longint'(de)), flip_de);
        a_ra = fold_angle(widen_q16(longint'(ra)), flip_ra);
        r    = widen_q16(longint'(rho));
        cordic_rotate(round_down_shift(r * GAIN_Q32, 32), a_de, p, zc);
        if (flip_de) begin
            p  = -p;
            zc = -zc;
        end
        cordic_rotate(round_down_shift(p * GAIN_Q32, 32), a_ra, xc, yc);
        if (flip_ra) begin
            xc = -xc;
            yc = -yc;
        end
        pos.x = clamp_position(xc);
        pos.y = clamp_position(yc);
        pos.z = clamp_position(zc);
        return pos;
    endfunction

    // ------------------------------------------------------------------
    // clock, receiver, checker, watchdog
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver: random idling, or a long hold-off counted here when asked for
    initial begin : receiver
        int unsigned hold_left;
        hold_left       = 0;
        result_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_left        = HOLD_OFF_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // every result taken is compared with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (pending_positions.size() == 0) begin
                $error("result with no request pending: x=%0d y=%0d z=%0d",
                       result_ch.pos_x, result_ch.pos_y, result_ch.pos_z);
                error_count++;
            end else begin : compare
                t_position want;
                want = pending_positions.pop_front();
                if (result_ch.pos_x !== want.x) begin
                    $error("pos_x: expected %0d, actual %0d", want.x, result_ch.pos_x);
                    error_count++;
                end
                if (result_ch.pos_y !== want.y) begin
                    $error("pos_y: expected %0d, actual %0d", want.y, result_ch.pos_y);
                    error_count++;
                end
                if (result_ch.pos_z !== want.z) begin
                    $error("pos_z: expected %0d, actual %0d", want.z, result_ch.pos_z);
                    error_count++;
                end
            end
        end
    end

    // hang detection: counts cycles in which neither channel moves anything
    always @(posedge i_clk) begin
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offer one request, idling first at random; returns at the accepting edge
    // with the prediction queued
    task automatic send_request(input int ra, input int de, input int rho);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            request_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        request_ch.valid           <= 1'b1;
        request_ch.right_ascension <= t_angle'(ra);
        request_ch.declination     <= t_angle'(de);
        request_ch.radius          <= t_radius'(rho);
        do begin
            @(posedge i_clk);
        end while (!request_ch.ready);
        pending_positions.push_back(predict_position(t_angle'(ra), t_angle'(de),
                                                     t_radius'(rho)));
    endtask

    // angle near zero, pi/2, pi or 2*pi, up to 4 lsb either side, with a random sign
    function automatic int boundary_angle();
        int marks [4];
        int a;
        marks[0] = PI_Q16;
        marks[1] = HPI_Q16;
        marks[2] = TWO_PI_Q16;
        marks[3] = 0;
        a = marks[$urandom_range(0, 3)] + $urandom_range(0, 8) - 4;
        if ($urandom_range(0, 1) == 1) begin
            a = -a;
        end
        return a;
    endfunction

    function automatic int random_angle();
        if ($urandom_range(0, 99) < 80) begin
            return int'(t_angle'($urandom_range(0, 20'hFFFFF)));
        end
        return boundary_angle();
    endfunction

    function automatic int random_radius();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
            return $urandom_range(0, RADIUS_MAX);
        end else if (pick < 90) begin
            return RADIUS_MAX - $urandom_range(0, 3);
        end
        return $urandom_range(0, 3);
    endfunction

    // field extremes, zero radius and full scale
    task automatic test_field_extremes();
        send_request(0, 0, 0);
        send_request(0, 0, RADIUS_MAX);
        send_request(ANGLE_MIN, ANGLE_MIN, RADIUS_MAX);
        send_request(ANGLE_MAX, ANGLE_MAX, RADIUS_MAX);
        send_request(ANGLE_MAX, ANGLE_MIN, RADIUS_ONE);
        send_request(ANGLE_MIN, ANGLE_MAX, 1);
    endtask

    // right ascension on both sides of pi/2 and pi, declination around pi/2 and past pi
    task automatic test_angle_folding();
        send_request(PI_Q16, 0, RADIUS_ONE);
        send_request(PI_Q16 + 1, 0, RADIUS_ONE);
        send_request(-PI_Q16, 0, RADIUS_ONE);
        send_request(-PI_Q16 - 1, 0, RADIUS_ONE);
        send_request(HPI_Q16, 0, RADIUS_ONE);
        send_request(HPI_Q16 + 1, 0, RADIUS_ONE);
        send_request(-HPI_Q16, 0, RADIUS_ONE);
        send_request(-HPI_Q16 - 1, 0, RADIUS_ONE);
        send_request(0, HPI_Q16, RADIUS_ONE);
        send_request(0, HPI_Q16 + 1, RADIUS_ONE);
        send_request(0, -HPI_Q16 - 1, RADIUS_ONE);
        send_request(0, PI_Q16 + 1, RADIUS_ONE);
    endtask

    // full radius along the axes pushes the outputs past their range
    task automatic test_output_saturation();
        send_request(PI_Q16, 0, RADIUS_MAX);
        send_request(0, HPI_Q16 - 1, RADIUS_MAX);
        send_request(0, -HPI_Q16 + 1, RADIUS_MAX);
        send_request(PI_Q16, PI_Q16, RADIUS_MAX);
    endtask

    task automatic test_random_stream(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_request(random_angle(), random_angle(), random_radius());
        end
    endtask

    // receiver holds off long enough for the pipe to fill and stall requests
    task automatic test_backpressure();
        hold_off_pending = 1'b1;
        test_random_stream(150);
    endtask

    initial begin
        error_count                = 0;
        idle_cycles                = 0;
        hold_off_pending           = 1'b0;
        src_idle_pct               = 29;
        sink_idle_pct              = 59;
        i_rst_n                    = 1'b0;
        request_ch.valid           = 1'b0;
        request_ch.right_ascension = '0;
        request_ch.declination     = '0;
        request_ch.radius          = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_angle_folding();
        test_output_saturation();

        // sender idles less than the receiver
        test_random_stream(250);
        // and the other way round
        src_idle_pct  = 59;
        sink_idle_pct = 29;
        test_random_stream(250);
        // full rate on both sides
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_stream(250);
        test_backpressure();

        request_ch.valid <= 1'b0;

        // drain the pipe, then give stray results a chance to show up
        while (pending_positions.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 16) @(posedge i_clk);

        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
